// File: hdl/tri3d_pkg.sv
// shared constants and types for the triangle area unit
package tri3d_pkg;

   // default coordinate width of one corner component
   localparam int COORD_BITS_DEF = 16;

   // corner components in one input item
   localparam int FIELD_COUNT = 9;

   // width of the area result and of the padded result bus
   localparam int AREA_BITS = 34;
   localparam int RSP_DATA_BITS = ((AREA_BITS + 7) / 8) * 8;

   typedef logic [AREA_BITS-1:0] area_type;

endpackage

// File: hdl/tri3d_cross.sv
// edge vectors and cross product, three register stages
module tri3d_cross #(
   parameter int COORD_BITS = tri3d_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            run,
   input  logic                            in_valid,
   input  logic [tri3d_pkg::FIELD_COUNT*COORD_BITS-1:0] in_coords,
   output logic                            out_valid,
   output logic signed [2*COORD_BITS+1:0]  cross_x,
   output logic signed [2*COORD_BITS+1:0]  cross_y,
   output logic signed [2*COORD_BITS+1:0]  cross_z
);

   localparam int EDGE_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * EDGE_BITS;

   logic signed [COORD_BITS-1:0] corner [tri3d_pkg::FIELD_COUNT];
   logic signed [EDGE_BITS-1:0]  edge_u_in [3];
   logic signed [EDGE_BITS-1:0]  edge_v_in [3];
   logic signed [EDGE_BITS-1:0]  edge_u_ff [3];
   logic signed [EDGE_BITS-1:0]  edge_v_ff [3];
   logic signed [PROD_BITS-1:0]  prod_in [6];
   logic signed [PROD_BITS-1:0]  prod_ff [6];
   logic signed [PROD_BITS-1:0]  cross_in [3];
   logic signed [PROD_BITS-1:0]  cross_ff [3];
   logic [2:0]                   valid_in;
   logic [2:0]                   valid_ff;

   // unpack the nine corner components, first x in the lowest bits
   always_comb begin
      for (int k = 0; k < tri3d_pkg::FIELD_COUNT; k++) begin
         corner[k] = $signed(in_coords[k*COORD_BITS +: COORD_BITS]);
      end
   end

   // edges from the first corner to the second and to the third
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         edge_u_in[k] = EDGE_BITS'(corner[3+k]) - EDGE_BITS'(corner[k]);
         edge_v_in[k] = EDGE_BITS'(corner[6+k]) - EDGE_BITS'(corner[k]);
      end
   end

   // the six cross terms
   always_comb begin
      prod_in[0] = edge_u_ff[1] * edge_v_ff[2];
      prod_in[1] = edge_u_ff[2] * edge_v_ff[1];
      prod_in[2] = edge_u_ff[2] * edge_v_ff[0];
      prod_in[3] = edge_u_ff[0] * edge_v_ff[2];
      prod_in[4] = edge_u_ff[0] * edge_v_ff[1];
      prod_in[5] = edge_u_ff[1] * edge_v_ff[0];
   end

   // cross product components, exact in PROD_BITS
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cross_in[k] = prod_ff[2*k] - prod_ff[2*k+1];
      end
   end

   assign valid_in = {valid_ff[1:0], in_valid};

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (run) begin
         valid_ff <= valid_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (run) begin
         edge_u_ff <= edge_u_in;
         edge_v_ff <= edge_v_in;
         prod_ff   <= prod_in;
         cross_ff  <= cross_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign cross_x   = cross_ff[0];
   assign cross_y   = cross_ff[1];
   assign cross_z   = cross_ff[2];

endmodule

// File: hdl/tri3d_square.sv
// magnitudes, split squares and sum of squares, four register stages
module tri3d_square #(
   parameter int COORD_BITS = tri3d_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           run,
   input  logic                           in_valid,
   input  logic signed [2*COORD_BITS+1:0] cross_x,
   input  logic signed [2*COORD_BITS+1:0] cross_y,
   input  logic signed [2*COORD_BITS+1:0] cross_z,
   output logic                           out_valid,
   output logic [4*COORD_BITS+3:0]        out_sum
);

   localparam int CROSS_BITS = 2 * COORD_BITS + 2;
   localparam int MAG_BITS   = CROSS_BITS - 1;
   localparam int LO_BITS    = (MAG_BITS + 1) / 2;
   localparam int HI_BITS    = MAG_BITS - LO_BITS;
   localparam int SQ_BITS    = 2 * MAG_BITS;
   localparam int SUM_BITS   = SQ_BITS + 2;

   logic signed [CROSS_BITS-1:0]     cross_c [3];
   logic [CROSS_BITS-1:0]            neg_c [3];
   logic [MAG_BITS-1:0]              mag_in [3];
   logic [MAG_BITS-1:0]              mag_ff [3];
   logic [2*LO_BITS-1:0]             ll_in [3];
   logic [HI_BITS+LO_BITS-1:0]       lh_in [3];
   logic [2*HI_BITS-1:0]             hh_in [3];
   logic [2*LO_BITS-1:0]             ll_ff [3];
   logic [HI_BITS+LO_BITS-1:0]       lh_ff [3];
   logic [2*HI_BITS-1:0]             hh_ff [3];
   logic [SQ_BITS-1:0]               sq_in [3];
   logic [SQ_BITS-1:0]               sq_ff [3];
   logic [SUM_BITS-1:0]              sum_in;
   logic [SUM_BITS-1:0]              sum_ff;
   logic [3:0]                       valid_in;
   logic [3:0]                       valid_ff;

   assign cross_c[0] = cross_x;
   assign cross_c[1] = cross_y;
   assign cross_c[2] = cross_z;

   // absolute value; the largest component magnitude fits in MAG_BITS
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         neg_c[k]  = CROSS_BITS'(-cross_c[k]);
         mag_in[k] = cross_c[k][CROSS_BITS-1] ? neg_c[k][MAG_BITS-1:0]
                                              : cross_c[k][MAG_BITS-1:0];
      end
   end

   // partial products of the low and high halves
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ll_in[k] = mag_ff[k][LO_BITS-1:0] * mag_ff[k][LO_BITS-1:0];
         lh_in[k] = mag_ff[k][MAG_BITS-1:LO_BITS] * mag_ff[k][LO_BITS-1:0];
         hh_in[k] = mag_ff[k][MAG_BITS-1:LO_BITS] * mag_ff[k][MAG_BITS-1:LO_BITS];
      end
   end

   // recombine each square
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = (SQ_BITS'(hh_ff[k]) << (2 * LO_BITS))
                  + (SQ_BITS'(lh_ff[k]) << (LO_BITS + 1))
                  + SQ_BITS'(ll_ff[k]);
      end
   end

   // squared norm of the cross product
   assign sum_in = SUM_BITS'(sq_ff[0]) + SUM_BITS'(sq_ff[1]) + SUM_BITS'(sq_ff[2]);

   assign valid_in = {valid_ff[2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (run) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         mag_ff <= mag_in;
         ll_ff  <= ll_in;
         lh_ff  <= lh_in;
         hh_ff  <= hh_in;
         sq_ff  <= sq_in;
         sum_ff <= sum_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_sum   = sum_ff;

endmodule

// File: hdl/tri3d_isqrt.sv
// integer square root, one result bit per register stage
module tri3d_isqrt #(
   parameter int COORD_BITS = tri3d_pkg::COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      run,
   input  logic                      in_valid,
   input  logic [4*COORD_BITS+3:0]   in_sum,
   output logic                      out_valid,
   output logic [2*COORD_BITS+1:0]   out_root
);

   localparam int ROOT_BITS = 2 * COORD_BITS + 2;
   localparam int SUM_BITS  = 2 * ROOT_BITS;
   localparam int REM_BITS  = ROOT_BITS + 2;

   logic [SUM_BITS-1:0]  rad_in  [ROOT_BITS];
   logic [REM_BITS-1:0]  rem_in  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_in [ROOT_BITS];
   logic [SUM_BITS-1:0]  rad_ff  [ROOT_BITS];
   logic [REM_BITS-1:0]  rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];
   logic [ROOT_BITS-1:0] valid_in;
   logic [ROOT_BITS-1:0] valid_ff;

   // each stage brings down two radicand bits and tries one root bit
   always_comb begin
      logic [SUM_BITS-1:0]  rad_prev;
      logic [REM_BITS-1:0]  rem_prev;
      logic [ROOT_BITS-1:0] root_prev;
      logic [REM_BITS-1:0]  rem_shift;
      logic [REM_BITS-1:0]  trial;
      logic                 fits;
      for (int s = 0; s < ROOT_BITS; s++) begin
         if (s == 0) begin
            rad_prev  = in_sum;
            rem_prev  = '0;
            root_prev = '0;
         end else begin
            rad_prev  = rad_ff[s-1];
            rem_prev  = rem_ff[s-1];
            root_prev = root_ff[s-1];
         end
         rem_shift  = {rem_prev[REM_BITS-3:0], rad_prev[SUM_BITS-1 -: 2]};
         trial      = {root_prev, 2'b01};
         fits       = (rem_shift >= trial);
         rad_in[s]  = rad_prev << 2;
         rem_in[s]  = fits ? (rem_shift - trial) : rem_shift;
         root_in[s] = {root_prev[ROOT_BITS-2:0], fits};
      end
   end

   assign valid_in = {valid_ff[ROOT_BITS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (run) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_valid = valid_ff[ROOT_BITS-1];
   assign out_root  = root_ff[ROOT_BITS-1];

endmodule

// File: hdl/triangle_area_3d_unit.sv
// top level of the triangle area unit: pipeline, output register and skid stage
//
// Takes one triangle per item on the req_ stream: nine signed corner
// coordinates packed in req_tdata. Returns one item per triangle on the
// rsp_ stream: floor of the norm of the edge cross product, which is twice
// the area, saturated to 34 bits.
// A new item can be accepted on every clock while the skid register is
// empty; throughput is then one item per cycle. A result passes through
// three stages for edges and cross product, four for magnitudes, split
// squares and their sum, one stage per root bit in the square root chain
// (2*COORD_BITS+2 bits), and the output register.
// When the receiver stalls, one more result is parked in a skid register;
// while it is full the whole pipeline holds and req_tready is low. Nothing
// is dropped or repeated. req_tready is a register output.
// Synchronous reset empties the pipeline, the output register and the skid
// register; the block keeps no other state.
module triangle_area_3d_unit #(
   parameter int COORD_BITS = tri3d_pkg::COORD_BITS_DEF,
   localparam int REQ_DATA_BITS = ((tri3d_pkg::FIELD_COUNT * COORD_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z,
   // third_x, third_y, third_z, each COORD_BITS wide, then zero pad
   input  logic [REQ_DATA_BITS-1:0]            req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // area_value (34 bits), then zero pad
   output logic [tri3d_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int ROOT_BITS = 2 * COORD_BITS + 2;
   localparam int AREA_BITS = tri3d_pkg::AREA_BITS;
   localparam int RSP_BITS  = tri3d_pkg::RSP_DATA_BITS;

   logic                          run;
   logic                          in_valid;
   logic                          cross_valid;
   logic signed [2*COORD_BITS+1:0] cross_x;
   logic signed [2*COORD_BITS+1:0] cross_y;
   logic signed [2*COORD_BITS+1:0] cross_z;
   logic                          sum_valid;
   logic [4*COORD_BITS+3:0]       sum;
   logic                          tail_valid;
   logic [ROOT_BITS-1:0]          tail_root;
   tri3d_pkg::area_type           tail_area;
   logic                          take;
   logic                          rsp_valid_in;
   logic                          rsp_valid_ff;
   tri3d_pkg::area_type           rsp_area_in;
   tri3d_pkg::area_type           rsp_area_ff;
   logic                          skid_valid_in;
   logic                          skid_valid_ff;
   tri3d_pkg::area_type           skid_area_in;
   tri3d_pkg::area_type           skid_area_ff;

   // the pipeline moves whenever the skid register is empty
   assign run        = !skid_valid_ff;
   assign req_tready = !skid_valid_ff;
   assign in_valid   = req_tvalid && req_tready;

   tri3d_cross #(.COORD_BITS(COORD_BITS)) u_cross (
      .clock     (clock),
      .reset     (reset),
      .run       (run),
      .in_valid  (in_valid),
      .in_coords (req_tdata[tri3d_pkg::FIELD_COUNT*COORD_BITS-1:0]),
      .out_valid (cross_valid),
      .cross_x   (cross_x),
      .cross_y   (cross_y),
      .cross_z   (cross_z)
   );

   tri3d_square #(.COORD_BITS(COORD_BITS)) u_square (
      .clock     (clock),
      .reset     (reset),
      .run       (run),
      .in_valid  (cross_valid),
      .cross_x   (cross_x),
      .cross_y   (cross_y),
      .cross_z   (cross_z),
      .out_valid (sum_valid),
      .out_sum   (sum)
   );

   tri3d_isqrt #(.COORD_BITS(COORD_BITS)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .run       (run),
      .in_valid  (sum_valid),
      .in_sum    (sum),
      .out_valid (tail_valid),
      .out_root  (tail_root)
   );

   // saturate the root to the result width
   if (ROOT_BITS > AREA_BITS) begin : g_sat
      assign tail_area = (|tail_root[ROOT_BITS-1:AREA_BITS]) ? '1
                                                              : tail_root[AREA_BITS-1:0];
   end else begin : g_ext
      assign tail_area = AREA_BITS'(tail_root);
   end

   // output register with skid stage
   always_comb begin
      take          = rsp_valid_ff && rsp_tready;
      rsp_valid_in  = rsp_valid_ff;
      rsp_area_in   = rsp_area_ff;
      skid_valid_in = skid_valid_ff;
      skid_area_in  = skid_area_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_area_in   = skid_area_ff;
            skid_valid_in = 1'b0;
         end
      end else if (tail_valid) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_in = 1'b1;
            rsp_area_in  = tail_area;
         end else begin
            skid_valid_in = 1'b1;
            skid_area_in  = tail_area;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_area_ff  <= rsp_area_in;
      skid_area_ff <= skid_area_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'(rsp_area_ff);

endmodule

// File: hdl/tri3d_checker.sv
// port-level checks for the triangle area unit, bound to the top level
module tri3d_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [tri3d_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   // a stalled result item holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // input is only held off while a result waits at the output
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input held off with no result waiting");

   // ready only drops after a stall at the output
   a_ready_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(rsp_tvalid && !rsp_tready))
      else $error("input ready fell without an output stall");

   // padding above the area field stays zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[tri3d_pkg::RSP_DATA_BITS-1:tri3d_pkg::AREA_BITS] == '0)
      else $error("result padding not zero");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("output not empty after reset");

endmodule

bind triangle_area_3d_unit tri3d_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
